// ----- hdl/position_keeping_engine_assert.svh -----
// Assertion macros shared by the position keeping engine.
`ifndef POSITION_KEEPING_ENGINE_ASSERT_SVH
`define POSITION_KEEPING_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PKE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PKE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pke_pkg.sv -----
package pke_pkg;

    localparam int NUM_INSTRUMENTS = 64;
    localparam int INST_W = $clog2(NUM_INSTRUMENTS);
    localparam int CASH_W = 63;

    localparam logic [1:0] KIND_SIGNAL = 2'd0;
    localparam logic [1:0] KIND_FILL = 2'd1;
    localparam logic [1:0] KIND_PRICE = 2'd2;

    localparam logic [2:0] ST_ORDER = 3'd0;
    localparam logic [2:0] ST_NOFUNDS = 3'd1;
    localparam logic [2:0] ST_FILLED = 3'd2;
    localparam logic [2:0] ST_BADDATA = 3'd3;
    localparam logic [2:0] ST_BADSELL = 3'd4;
    localparam logic [2:0] ST_SNAPSHOT = 3'd5;

    localparam logic [30:0] QTY_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic        side;
        logic [5:0]  instrument;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [63:0] timestamp;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] order_number;
        logic        order_side;
        logic [5:0]  order_instrument;
        logic [31:0] order_price;
        logic [31:0] order_quantity;
        logic [63:0] event_time;
        logic [63:0] cash_now;
        logic [63:0] equity;
        logic [63:0] realized_total;
    } out_item_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_READ,
        CMD_DECIDE,
        CMD_MUL,
        CMD_DIV_START,
        CMD_DIV_STEP,
        CMD_WRITE,
        CMD_SCAN_START,
        CMD_SCAN_READ,
        CMD_SCAN_ACC,
        CMD_FINISH
    } cmd_t;

    typedef struct packed {
        logic is_fill_sell;
        logic is_fill_buy;
        logic is_snapshot;
        logic done_early;
        logic div_last;
        logic scan_last;
    } status_t;

    function automatic logic [31:0] magnitude32(input logic [31:0] raw);
        magnitude32 = raw[31] ? (~raw + 32'd1) : raw;
    endfunction

endpackage

// ----- hdl/pke_ram.sv -----
module pke_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/pke_ctrl.sv -----
module pke_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  pke_pkg::status_t st,
    output pke_pkg::cmd_t    cmd
);
    import pke_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_DECIDE, S_MUL, S_DIVS, S_DIV, S_WRITE,
        S_SCANS, S_SCANR, S_SCANA, S_FIN, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        cmd = CMD_NONE;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !out_valid_reg)
                begin
                    cmd = CMD_LOAD;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd = CMD_READ;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd = CMD_DECIDE;
                if (st.done_early)
                    state_next = S_FIN;
                else if (st.is_snapshot)
                    state_next = S_SCANS;
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd = CMD_MUL;
                state_next = st.is_fill_buy ? S_DIVS : S_WRITE;
            end
            S_DIVS:
            begin
                cmd = CMD_DIV_START;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd = CMD_DIV_STEP;
                if (st.div_last)
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd = CMD_WRITE;
                state_next = S_FIN;
            end
            S_SCANS:
            begin
                cmd = CMD_SCAN_START;
                state_next = S_SCANR;
            end
            S_SCANR:
            begin
                cmd = CMD_SCAN_READ;
                state_next = S_SCANA;
            end
            S_SCANA:
            begin
                cmd = CMD_SCAN_ACC;
                state_next = st.scan_last ? S_FIN : S_SCANR;
            end
            S_FIN:
            begin
                cmd = CMD_FINISH;
                out_valid_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall = !(state_reg == S_IDLE && !out_valid_reg);
    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/pke_datapath.sv -----
module pke_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [62:0]         cfg_data,
    input  pke_pkg::in_item_t   in_item,
    input  pke_pkg::cmd_t       cmd,
    output pke_pkg::status_t    st,
    output pke_pkg::out_item_t  out_item
);
    import pke_pkg::*;

    in_item_t    it_reg;
    logic [31:0] qty_reg;
    logic [63:0] cash_reg, real_reg;
    logic [31:0] ocnt_reg;
    logic [NUM_INSTRUMENTS-1:0] known_reg, nz_reg;
    logic [2:0]  stat_reg, stat_next;
    logic        sell_reg, buy_reg, snap_reg;
    logic [63:0] prod_reg, acc_reg;
    logic [63:0] num_reg;
    logic [31:0] quo_reg;
    logic [30:0] den_reg;
    logic [31:0] rem_reg;
    logic [5:0]  dcnt_reg;
    logic [INST_W:0] scan_reg;
    logic        scan_v_reg;
    logic        sh_reg;
    out_item_t   out_reg, out_next;

    logic [30:0] held_rd;
    logic [31:0] avg_rd, close_rd;
    logic [63:0] preal_rd;
    logic        we_pos;
    logic [30:0] held_wd;
    logic [31:0] avg_wd;
    logic [63:0] preal_wd;
    logic [INST_W-1:0] raddr, inst_a;
    logic [31:0] nq;
    logic [32:0] rem_sh;
    logic [30:0] held_v;
    logic [31:0] avg_v;
    logic [63:0] preal_v;
    logic        early_decide;

    assign inst_a = it_reg.instrument[INST_W-1:0];
    assign raddr = (cmd == CMD_SCAN_START || cmd == CMD_SCAN_READ || cmd == CMD_SCAN_ACC)
                   ? scan_reg[INST_W-1:0] : inst_a;
    assign nq = {1'b0, held_v} + qty_reg;

    always_comb
    begin
        held_wd = held_v;
        avg_wd = avg_v;
        preal_wd = preal_v;
        we_pos = (cmd == CMD_WRITE);
        if (sell_reg)
        begin
            held_wd = held_v - qty_reg[30:0];
            preal_wd = preal_v + prod_reg;
            if (held_wd == 31'd0)
                avg_wd = 32'd0;
        end
        else
        begin
            held_wd = nq[30:0];
            avg_wd = quo_reg;
        end
    end

    pke_ram #(.WIDTH(31), .DEPTH(NUM_INSTRUMENTS)) u_held (
        .clk(clk), .we(we_pos), .waddr(inst_a), .wdata(held_wd),
        .raddr(raddr), .rdata(held_rd));
    pke_ram #(.WIDTH(32), .DEPTH(NUM_INSTRUMENTS)) u_avg (
        .clk(clk), .we(we_pos), .waddr(inst_a), .wdata(avg_wd),
        .raddr(raddr), .rdata(avg_rd));
    pke_ram #(.WIDTH(64), .DEPTH(NUM_INSTRUMENTS)) u_preal (
        .clk(clk), .we(we_pos), .waddr(inst_a), .wdata(preal_wd),
        .raddr(raddr), .rdata(preal_rd));
    pke_ram #(.WIDTH(32), .DEPTH(NUM_INSTRUMENTS)) u_close (
        .clk(clk), .we(cmd == CMD_DECIDE && snap_reg),
        .waddr(inst_a), .wdata(it_reg.price),
        .raddr(raddr), .rdata(close_rd));

    // Held quantity and average cost read as zero until first written.
    assign held_v = nz_reg[raddr] ? held_rd : 31'd0;
    assign avg_v = nz_reg[raddr] ? avg_rd : 32'd0;
    assign preal_v = nz_reg[raddr] ? preal_rd : 64'd0;

    assign rem_sh = {rem_reg, num_reg[63]};

    always_comb
    begin
        stat_next = ST_BADDATA;
        case (it_reg.kind)
            KIND_SIGNAL: stat_next = ST_ORDER;
            KIND_FILL: stat_next = ST_FILLED;
            KIND_PRICE: stat_next = ST_SNAPSHOT;
            default: stat_next = ST_BADDATA;
        endcase
    end

    always_comb
    begin
        out_next = '0;
        out_next.status = stat_reg;
        out_next.cash_now = cash_reg;
        out_next.realized_total = real_reg;
        if (stat_reg == ST_ORDER)
        begin
            out_next.order_number = ocnt_reg;
            out_next.order_side = it_reg.side;
            out_next.order_instrument = it_reg.instrument;
            out_next.order_price = it_reg.price;
            out_next.order_quantity = qty_reg;
            out_next.event_time = it_reg.timestamp;
        end
        if (stat_reg == ST_SNAPSHOT)
        begin
            out_next.event_time = it_reg.timestamp;
            out_next.equity = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cash_reg <= 64'd0;
            real_reg <= 64'd0;
            ocnt_reg <= 32'd0;
            known_reg <= '0;
            nz_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                cash_reg <= {1'b0, cfg_data};
            if (cmd == CMD_DECIDE && snap_reg)
                known_reg[inst_a] <= 1'b1;
            if (cmd == CMD_WRITE)
            begin
                nz_reg[inst_a] <= 1'b1;
                if (sell_reg)
                begin
                    cash_reg <= cash_reg + acc_reg;
                    real_reg <= real_reg + prod_reg;
                end
                else
                begin
                    cash_reg <= cash_reg - acc_reg;
                end
            end
            if (cmd == CMD_FINISH && stat_reg == ST_ORDER)
                ocnt_reg <= ocnt_reg + 32'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                it_reg <= in_item;
                qty_reg <= magnitude32(in_item.quantity);
            end
            CMD_READ:
            begin
                stat_reg <= stat_next;
                snap_reg <= (it_reg.kind == KIND_PRICE);
                sell_reg <= 1'b0;
                buy_reg <= 1'b0;
                prod_reg <= {32'd0, it_reg.price} * {32'd0, qty_reg};
            end
            CMD_DECIDE:
            begin
                if (it_reg.kind == KIND_SIGNAL)
                begin
                    if (!it_reg.side && !(!cash_reg[63] && cash_reg > prod_reg))
                        stat_reg <= ST_NOFUNDS;
                end
                else if (it_reg.kind == KIND_FILL)
                begin
                    if (qty_reg == 32'd0 || it_reg.price == 32'd0
                        || {26'd0, it_reg.instrument} >= NUM_INSTRUMENTS)
                        stat_reg <= ST_BADDATA;
                    else if (it_reg.side)
                    begin
                        if (held_v != 31'd0 && {1'b0, held_v} >= qty_reg)
                        begin
                            sell_reg <= 1'b1;
                            acc_reg <= prod_reg;
                        end
                        else
                            stat_reg <= ST_BADSELL;
                    end
                    else
                    begin
                        if ({1'b0, held_v} + {1'b0, qty_reg} <= {2'b0, QTY_MAX})
                        begin
                            buy_reg <= 1'b1;
                            acc_reg <= prod_reg;
                        end
                        else
                            stat_reg <= ST_BADDATA;
                    end
                end
            end
            CMD_MUL:
            begin
                if (sell_reg)
                    prod_reg <= prod_reg - {32'd0, avg_v} * {32'd0, qty_reg};
                else
                    num_reg <= prod_reg + {32'd0, avg_v} * {33'd0, held_v};
                den_reg <= nq[30:0];
            end
            CMD_DIV_START:
            begin
                rem_reg <= 32'd0;
                quo_reg <= 32'd0;
                dcnt_reg <= 6'd0;
            end
            CMD_DIV_STEP:
            begin
                if (rem_sh >= {2'b0, den_reg})
                begin
                    rem_reg <= 32'(rem_sh - {2'b0, den_reg});
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                num_reg <= {num_reg[62:0], 1'b0};
                dcnt_reg <= dcnt_reg + 6'd1;
            end
            CMD_SCAN_START:
            begin
                scan_reg <= '0;
                acc_reg <= cash_reg;
                scan_v_reg <= 1'b0;
            end
            CMD_SCAN_READ:
            begin
                scan_v_reg <= 1'b1;
                sh_reg <= known_reg[scan_reg[INST_W-1:0]];
            end
            CMD_SCAN_ACC:
            begin
                if (sh_reg)
                    acc_reg <= acc_reg + {33'd0, held_v} * {32'd0, close_rd};
                scan_reg <= scan_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
        if (cmd == CMD_FINISH)
            out_reg <= out_next;
    end

    always_comb
    begin
        early_decide = 1'b1;
        if (it_reg.kind == KIND_FILL && qty_reg != 32'd0 && it_reg.price != 32'd0)
        begin
            if (it_reg.side)
                early_decide = !(held_v != 31'd0 && {1'b0, held_v} >= qty_reg);
            else
                early_decide = !({1'b0, held_v} + {1'b0, qty_reg} <= {2'b0, QTY_MAX});
        end
        else if (it_reg.kind == KIND_PRICE)
            early_decide = 1'b0;
    end

    // Sixty-four quotient bits are produced, but only the low 32 are kept;
    // the numerator is below 2^63 and the quotient fits 32 bits.
    assign st.is_fill_sell = sell_reg;
    assign st.is_fill_buy = buy_reg;
    assign st.is_snapshot = snap_reg;
    assign st.done_early = early_decide;
    assign st.div_last = (dcnt_reg == 6'd63);
    assign st.scan_last = (scan_reg == (INST_W+1)'(NUM_INSTRUMENTS - 1)) && scan_v_reg;

    assign out_item = out_reg;

endmodule

// ----- hdl/position_keeping_engine.sv -----
// Every item is loaded, read and decided; signals and rejected items then
// finish, sell fills add a multiply and a write, buy fills add a division of
// 64 quotient steps between the two, and price updates scan every instrument
// with a read and an accumulate step each. One item is in flight at a time;
// the next input is taken the cycle after the result transfer.
// Reset is asynchronous and active low and clears cash, profit and positions.
module position_keeping_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [62:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  pke_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output pke_pkg::out_item_t  out_data
);
    import pke_pkg::*;

    cmd_t    cmd;
    status_t st;

    pke_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_item(in_data), .cmd(cmd), .st(st), .out_item(out_data));

    pke_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .st(st), .cmd(cmd));

`include "position_keeping_engine_assert.svh"

    `PKE_ASSERT_IMPL(a_no_take_busy, clk, rst_n, out_valid, in_stall, "input taken while result pending")
    `PKE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")
    `PKE_ASSERT_IMPL(a_status_range, clk, rst_n, out_valid, out_data.status <= ST_SNAPSHOT, "bad status")

endmodule

// ----- sim/tb_position_keeping_engine.sv -----
module tb_position_keeping_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import pke_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [62:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_stall;
    out_item_t          out_data;

    position_keeping_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    // Book state held by the predictor.
    logic [63:0] book_cash;
    logic [63:0] book_realized;
    logic [31:0] book_orders;
    logic [30:0] book_qty [NUM_INSTRUMENTS];
    logic [31:0] book_avg [NUM_INSTRUMENTS];
    logic [63:0] book_pos_pnl [NUM_INSTRUMENTS];
    logic [31:0] book_close [NUM_INSTRUMENTS];
    logic        book_close_known [NUM_INSTRUMENTS];

    in_item_t  pending_items[$];
    out_item_t expected_results[$];
    int        error_count;
    int        transfers_in;
    int        transfers_out;
    int        status_seen [8];
    bit        hold_off;
    bit        quiet_phase;

    function automatic out_item_t book_apply(input in_item_t it);
        out_item_t   r;
        logic [31:0] mag;
        logic [63:0] cost;
        logic [63:0] pnl;
        logic [63:0] nq;
        logic [63:0] total;
        logic [63:0] eq;
        r = '0;
        r.status = ST_BADDATA;
        mag = it.quantity[31] ? (~it.quantity + 32'd1) : it.quantity;
        cost = {32'd0, it.price} * {32'd0, mag};
        if (it.kind == KIND_SIGNAL) begin
            if (it.side == 1'b1 || (!book_cash[63] && book_cash > cost)) begin
                r.status = ST_ORDER;
                r.order_number = book_orders;
                r.order_side = it.side;
                r.order_instrument = it.instrument;
                r.order_price = it.price;
                r.order_quantity = mag;
                r.event_time = it.timestamp;
                book_orders = book_orders + 32'd1;
            end
            else
            begin
                r.status = ST_NOFUNDS;
            end
        end
        else if (it.kind == KIND_FILL) begin
            if (mag != 0 && it.price != 0) begin
                if (it.side == 1'b1) begin
                    if (book_qty[it.instrument] != 0
                        && {1'b0, book_qty[it.instrument]} >= mag) begin
                        pnl = ({32'd0, it.price} - {32'd0, book_avg[it.instrument]})
                              * {32'd0, mag};
                        book_qty[it.instrument] = book_qty[it.instrument] - mag[30:0];
                        book_pos_pnl[it.instrument] = book_pos_pnl[it.instrument] + pnl;
                        book_realized = book_realized + pnl;
                        book_cash = book_cash + cost;
                        if (book_qty[it.instrument] == 0)
                            book_avg[it.instrument] = '0;
                        r.status = ST_FILLED;
                    end
                    else
                    begin
                        r.status = ST_BADSELL;
                    end
                end
                else
                begin
                    nq = {33'd0, book_qty[it.instrument]} + {32'd0, mag};
                    if (nq <= 64'h7FFF_FFFF) begin
                        total = cost + {32'd0, book_avg[it.instrument]}
                                * {33'd0, book_qty[it.instrument]};
                        book_avg[it.instrument] = 32'(total / nq);
                        book_qty[it.instrument] = nq[30:0];
                        book_cash = book_cash - cost;
                        r.status = ST_FILLED;
                    end
                end
            end
        end
        else if (it.kind == KIND_PRICE) begin
            book_close[it.instrument] = it.price;
            book_close_known[it.instrument] = 1'b1;
            eq = book_cash;
            for (int i = 0; i < NUM_INSTRUMENTS; i++)
                if (book_close_known[i])
                    eq = eq + {33'd0, book_qty[i]} * {32'd0, book_close[i]};
            r.equity = eq;
            r.event_time = it.timestamp;
            r.status = ST_SNAPSHOT;
        end
        r.cash_now = book_cash;
        r.realized_total = book_realized;
        return r;
    endfunction

    task automatic book_clear();
        book_cash = '0;
        book_realized = '0;
        book_orders = '0;
        for (int i = 0; i < NUM_INSTRUMENTS; i++)
        begin
            book_qty[i] = '0;
            book_avg[i] = '0;
            book_pos_pnl[i] = '0;
            book_close[i] = '0;
            book_close_known[i] = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("Mismatch on %s: got %h, expected %h", what, got, want);
    endtask

    function automatic logic [31:0] rand_qty();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return -$urandom_range(1, 500);
            4: return $urandom();
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    function automatic logic [31:0] rand_price();
        case ($urandom_range(0, 9))
            0: return 32'hFFFF_FFFF;
            1: return 32'd0;
            2: return $urandom();
            default: return $urandom_range(1, 2000000);
        endcase
    endfunction

    function automatic in_item_t make_item(input logic [1:0] k, input logic s,
                                           input logic [5:0] inst,
                                           input logic [31:0] p,
                                           input logic [31:0] q);
        in_item_t it;
        it.kind = k;
        it.side = s;
        it.instrument = inst;
        it.price = p;
        it.quantity = q;
        it.timestamp = {$urandom(), $urandom()};
        return it;
    endfunction

    function automatic in_item_t random_item();
        logic [1:0] k;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35) k = KIND_SIGNAL;
        else if (sel < 80) k = KIND_FILL;
        else if (sel < 97) k = KIND_PRICE;
        else k = 2'd3;
        return make_item(k, 1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0) ?
                         6'($urandom_range(0, 63)) : 6'($urandom_range(0, 5)),
                         rand_price(), rand_qty());
    endfunction

    task automatic load_cash(input logic [62:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        book_cash = {1'b0, value};
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_results.size() != 0 || in_valid)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && !in_stall) begin
                transfers_in++;
                expected_results.push_back(book_apply(in_data));
            end
            if (!in_valid || !in_stall) begin
                if (pending_items.size() != 0
                    && (quiet_phase || $urandom_range(0, 99) >= 26)) begin
                    in_valid <= 1'b1;
                    in_data <= pending_items.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall) begin
                out_item_t w;
                transfers_out++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transfer", 64'(out_data.status), 64'd0);
                end
                else
                begin
                    w = expected_results.pop_front();
                    status_seen[out_data.status]++;
                    if (out_data.status !== w.status)
                        report_mismatch("status", 64'(out_data.status), 64'(w.status));
                    if (out_data.order_number !== w.order_number)
                        report_mismatch("order_number", 64'(out_data.order_number),
                                        64'(w.order_number));
                    if (out_data.order_side !== w.order_side)
                        report_mismatch("order_side", 64'(out_data.order_side),
                                        64'(w.order_side));
                    if (out_data.order_instrument !== w.order_instrument)
                        report_mismatch("order_instrument", 64'(out_data.order_instrument),
                                        64'(w.order_instrument));
                    if (out_data.order_price !== w.order_price)
                        report_mismatch("order_price", 64'(out_data.order_price),
                                        64'(w.order_price));
                    if (out_data.order_quantity !== w.order_quantity)
                        report_mismatch("order_quantity", 64'(out_data.order_quantity),
                                        64'(w.order_quantity));
                    if (out_data.event_time !== w.event_time)
                        report_mismatch("event_time", out_data.event_time, w.event_time);
                    if (out_data.cash_now !== w.cash_now)
                        report_mismatch("cash_now", out_data.cash_now, w.cash_now);
                    if (out_data.equity !== w.equity)
                        report_mismatch("equity", out_data.equity, w.equity);
                    if (out_data.realized_total !== w.realized_total)
                        report_mismatch("realized_total", out_data.realized_total,
                                        w.realized_total);
                end
            end
            out_stall <= hold_off || (!quiet_phase && $urandom_range(0, 99) < 26);
        end
    end

    // The receiver holds off for a long stretch so that the input stalls.
    initial
    begin
        hold_off = 1'b0;
        wait (transfers_in > 300);
        hold_off = 1'b1;
        repeat (800) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #4ms;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        quiet_phase = 1'b0;
        error_count = 0;
        transfers_in = 0;
        transfers_out = 0;
        book_clear();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items with no cash: refused buys, sells, bad fills.
        pending_items.push_back(make_item(KIND_SIGNAL, 1'b0, 6'd0, 32'd1, 32'd1));
        pending_items.push_back(make_item(KIND_SIGNAL, 1'b1, 6'd63, 32'hFFFF_FFFF,
                                          32'h8000_0000));
        pending_items.push_back(make_item(KIND_FILL, 1'b1, 6'd1, 32'd100, 32'd5));
        pending_items.push_back(make_item(KIND_FILL, 1'b0, 6'd1, 32'd0, 32'd5));
        pending_items.push_back(make_item(KIND_FILL, 1'b0, 6'd1, 32'd10, 32'd0));
        pending_items.push_back(make_item(2'd3, 1'b1, 6'd2, 32'd5, 32'd5));
        pending_items.push_back(make_item(KIND_PRICE, 1'b0, 6'd63, 32'd0, 32'd0));
        drain();

        load_cash(63'h7FFF_FFFF_FFFF_FFFF);
        pending_items.push_back(make_item(KIND_SIGNAL, 1'b0, 6'd3, 32'hFFFF_FFFF,
                                          32'h7FFF_FFFF));
        pending_items.push_back(make_item(KIND_FILL, 1'b0, 6'd3, 32'd7, 32'h7FFF_FFFF));
        pending_items.push_back(make_item(KIND_FILL, 1'b0, 6'd3, 32'd7, 32'd1));
        pending_items.push_back(make_item(KIND_FILL, 1'b1, 6'd3, 32'hFFFF_FFFF,
                                          32'h8000_0001));
        pending_items.push_back(make_item(KIND_FILL, 1'b1, 6'd3, 32'd3, 32'h7FFF_FFFF));
        pending_items.push_back(make_item(KIND_FILL, 1'b0, 6'd4, 32'd10, -32'sd3));
        pending_items.push_back(make_item(KIND_FILL, 1'b0, 6'd4, 32'd13, 32'd4));
        pending_items.push_back(make_item(KIND_PRICE, 1'b1, 6'd4, 32'hFFFF_FFFF, 32'd0));
        pending_items.push_back(make_item(KIND_FILL, 1'b1, 6'd4, 32'd20, 32'd8));
        pending_items.push_back(make_item(KIND_FILL, 1'b1, 6'd4, 32'd20, 32'd7));
        pending_items.push_back(make_item(KIND_PRICE, 1'b0, 6'd0, 32'd9, 32'd0));
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: load_cash(63'd0);
                1: load_cash(63'd50_000_000);
                2: load_cash(63'({$urandom(), $urandom()}));
                default: load_cash(63'h7FFF_FFFF_FFFF_FFFF);
            endcase
            quiet_phase = (phase == 2);
            for (int n = 0; n < 360; n++)
                pending_items.push_back(random_item());
            drain();
        end

        $display("Transfers: %0d in, %0d out; orders %0d, refused %0d, fills %0d",
                 transfers_in, transfers_out, status_seen[ST_ORDER],
                 status_seen[ST_NOFUNDS], status_seen[ST_FILLED]);
        $display("Bad data %0d, bad sells %0d, snapshots %0d, mismatches %0d",
                 status_seen[ST_BADDATA], status_seen[ST_BADSELL],
                 status_seen[ST_SNAPSHOT], error_count);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
